### design/printf_integer_formatter_unit_assert.svh
// Assertion macros shared by the integer formatter RTL.
`ifndef PRINTF_INTEGER_FORMATTER_UNIT_ASSERT_SVH
`define PRINTF_INTEGER_FORMATTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIFU_ASSERT_IMP(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("pifu: %m check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIFU_ASSERT_NXT(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("pifu: %m check failed");

`endif

### design/pifu_pkg.sv
// Package with types, constants, character helpers and the control program of the formatter.
`default_nettype none

package pifu_pkg;

	// Default field width limit.
	localparam int MAX_WIDTH_DEF = 40;

	// Magnitude and digit store sizes.
	localparam int MAG_W = 64;
	localparam int NDIG = 20;
	localparam int ND_W = $clog2(NDIG + 1);
	localparam int BITS_PER_STEP = 2;
	localparam int CONV_STEPS = MAG_W / BITS_PER_STEP;
	localparam int CONV_W = $clog2(CONV_STEPS);

	// Conversion kinds; any other code formats as decimal.
	localparam logic [1:0] KIND_LHEX = 2'd1;
	localparam logic [1:0] KIND_UHEX = 2'd2;

	// ASCII characters.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;

	// Datapath action selected by a control word.
	typedef enum logic [2:0] {
		ACT_LOAD,
		ACT_CONV,
		ACT_SETUP,
		ACT_LPAD,
		ACT_SIGN,
		ACT_ZERO,
		ACT_DIGIT,
		ACT_RPAD
	} action_t;

	// Condition under which the sequencer jumps to the target step.
	typedef enum logic [1:0] {
		COND_REQ,
		COND_CONV_END,
		COND_ALWAYS,
		COND_SEG_DONE
	} cond_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE  = 3'd0;
	localparam step_t STEP_CONV  = 3'd1;
	localparam step_t STEP_SETUP = 3'd2;
	localparam step_t STEP_LPAD  = 3'd3;
	localparam step_t STEP_SIGN  = 3'd4;
	localparam step_t STEP_ZERO  = 3'd5;
	localparam step_t STEP_DIGIT = 3'd6;
	localparam step_t STEP_RPAD  = 3'd7;

	typedef struct packed {
		action_t act;
		cond_t   cond;
		step_t   target;
	} uword_t;

	// Control program: one word per step; the step holds until its condition is met.
	function automatic uword_t ucode_rom(input step_t pc);
		uword_t w;
		unique case (pc)
			STEP_IDLE:  w = '{act: ACT_LOAD,  cond: COND_REQ,      target: STEP_CONV};
			STEP_CONV:  w = '{act: ACT_CONV,  cond: COND_CONV_END, target: STEP_SETUP};
			STEP_SETUP: w = '{act: ACT_SETUP, cond: COND_ALWAYS,   target: STEP_LPAD};
			STEP_LPAD:  w = '{act: ACT_LPAD,  cond: COND_SEG_DONE, target: STEP_SIGN};
			STEP_SIGN:  w = '{act: ACT_SIGN,  cond: COND_SEG_DONE, target: STEP_ZERO};
			STEP_ZERO:  w = '{act: ACT_ZERO,  cond: COND_SEG_DONE, target: STEP_DIGIT};
			STEP_DIGIT: w = '{act: ACT_DIGIT, cond: COND_SEG_DONE, target: STEP_RPAD};
			STEP_RPAD:  w = '{act: ACT_RPAD,  cond: COND_SEG_DONE, target: STEP_IDLE};
		endcase
		return w;
	endfunction

	// ASCII character of one digit in the selected conversion kind.
	function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic [1:0] kind);
		logic [7:0] base;
		base = (kind == KIND_UHEX) ? CH_UP_A : CH_LOW_A;
		if (nib < 4'd10) begin
			return CH_ZERO + {4'h0, nib};
		end
		return base + {4'h0, nib} - 8'd10;
	endfunction

endpackage

`default_nettype wire

### design/printf_integer_formatter_unit.sv
// Integer formatter top level: microcoded sequencer, digit converter and character output.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  value, conv_kind, precision, field_width,
//                                            zero_pad, left_align
// rsp      out        rsp_valid / rsp_ready  out_char, is_last
//
// One request passes through acceptance, the shift-and-adjust digit converter (two
// magnitude bits per cycle), setup and the five text segments, each segment closing once
// it is empty; the text is 0..41 characters long at the default limit.
// Stalls on rsp hold the character sequencer.
// Reset clears the step counter, counters and the output valid; there is no clearing pass.
`default_nettype none
`include "printf_integer_formatter_unit_assert.svh"

module printf_integer_formatter_unit #(
	parameter int MAX_WIDTH = pifu_pkg::MAX_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire logic signed [63:0] value,
	input  wire logic        [1:0]  conv_kind,
	input  wire logic signed [6:0]  precision,
	input  wire logic        [5:0]  field_width,
	input  wire logic               zero_pad,
	input  wire logic               left_align,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output logic             [7:0]  out_char,
	output logic                    is_last
);

	// Counters hold up to MAX_WIDTH + 1 characters; setup math has one spare bit.
	localparam int CNT_W = $clog2(MAX_WIDTH + 2);
	localparam int A_W = CNT_W + 1;
	localparam int MAG_W = pifu_pkg::MAG_W;
	localparam int NDIG = pifu_pkg::NDIG;
	localparam int ND_W = pifu_pkg::ND_W;
	localparam int BCD_W = 4 * NDIG;
	localparam int CONV_W = pifu_pkg::CONV_W;

	// Sequencer state.
	pifu_pkg::step_t   pc_q;
	pifu_pkg::step_t   pc_d;
	pifu_pkg::uword_t  uw;
	logic              cond_met;

	// Request fields held for the whole request, but for the magnitude, which the converter shifts.
	logic [MAG_W-1:0]  mag_q;
	logic              neg_q;
	logic [1:0]        kind_q;
	logic              prec_pos_q;
	logic              prec_zero_q;
	logic [CNT_W-1:0]  prec_q;
	logic [CNT_W-1:0]  width_q;
	logic              zpad_q;
	logic              left_q;

	// Digit converter.
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  bcd_d;
	logic [MAG_W-1:0]  mag_d;
	logic [ND_W-1:0]   nd_q;
	logic              nd_grow;
	logic [pifu_pkg::CONV_W-1:0] conv_cnt_q;
	logic              is_dec;

	// Segment counters.
	logic [CNT_W-1:0]  lpad_q;
	logic              sign_q;
	logic [CNT_W-1:0]  zc_q;
	logic [ND_W-1:0]   dig_q;
	logic [CNT_W-1:0]  rpad_q;
	logic [CNT_W-1:0]  rem_q;

	// Setup results.
	logic [A_W-1:0]    s_nd;
	logic [A_W-1:0]    s_tgt;
	logic [A_W-1:0]    s_zeros;
	logic              s_ow;
	logic [A_W-1:0]    s_zc;
	logic [A_W-1:0]    s_nt;
	logic [A_W-1:0]    s_spaces;

	// Character path.
	logic              seg_zero;
	logic              emit_act;
	logic              emit;
	logic              slot_free;
	logic [7:0]        emit_char;
	logic [ND_W-1:0]   dig_idx;
	logic [3:0]        dig_nib;

	// Output register.
	logic              rsp_valid_q;
	logic [7:0]        out_char_q;
	logic              is_last_q;

	// Input saturation.
	logic [CNT_W-1:0]  prec_in;
	logic [CNT_W-1:0]  width_in;

	assign is_dec = (kind_q != pifu_pkg::KIND_LHEX) && (kind_q != pifu_pkg::KIND_UHEX);
	assign req_ready = (pc_q == pifu_pkg::STEP_IDLE);
	assign slot_free = !rsp_valid_q || rsp_ready;

	// Control word fetch and jump decision.
	always_comb begin
		uw = pifu_pkg::ucode_rom(pc_q);
		unique case (uw.cond)
			pifu_pkg::COND_REQ:      cond_met = req_valid;
			pifu_pkg::COND_CONV_END: cond_met = (conv_cnt_q == '1);
			pifu_pkg::COND_ALWAYS:   cond_met = 1'b1;
			pifu_pkg::COND_SEG_DONE: cond_met = seg_zero;
		endcase
		pc_d = cond_met ? uw.target : pc_q;
	end

	// Saturate precision and width to the field limit.
	always_comb begin
		prec_in = (int'(precision[5:0]) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(precision[5:0]);
		width_in = (int'(field_width) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(field_width);
	end

	// Two shift-and-adjust steps per cycle; the digit count grows by at most one.
	always_comb begin
		bcd_d = bcd_q;
		mag_d = mag_q;
		nd_grow = 1'b0;
		for (int s = 0; s < pifu_pkg::BITS_PER_STEP; s++) begin
			if (is_dec) begin
				for (int i = 0; i < NDIG; i++) begin
					if (bcd_d[4*i +: 4] >= 4'd5) begin
						bcd_d[4*i +: 4] = bcd_d[4*i +: 4] + 4'd3;
					end
				end
			end
			bcd_d = {bcd_d[BCD_W-2:0], mag_d[MAG_W-1]};
			mag_d = {mag_d[MAG_W-2:0], 1'b0};
		end
		for (int i = 0; i < NDIG; i++) begin
			if ((ND_W'(i) == nd_q) && (bcd_d[4*i +: 4] != 4'd0)) begin
				nd_grow = 1'b1;
			end
		end
	end

	// Segment lengths: zeros, sign overwrite, spaces and total length.
	always_comb begin
		if (nd_q == '0) begin
			s_nd = prec_zero_q ? '0 : A_W'(1);
		end else begin
			s_nd = A_W'(nd_q);
		end
		if (prec_pos_q) begin
			s_tgt = A_W'(prec_q);
		end else if (zpad_q && !left_q) begin
			s_tgt = A_W'(width_q);
		end else begin
			s_tgt = '0;
		end
		s_zeros = (s_tgt > s_nd) ? (s_tgt - s_nd) : '0;
		s_ow = !prec_pos_q && (s_zeros != '0) && neg_q;
		s_zc = s_zeros - A_W'(s_ow);
		s_nt = A_W'(neg_q) + s_zc + s_nd;
		s_spaces = (A_W'(width_q) > s_nt) ? (A_W'(width_q) - s_nt) : '0;
	end

	// Digit selection, most significant first.
	always_comb begin
		dig_idx = dig_q - ND_W'(1);
		dig_nib = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (ND_W'(i) == dig_idx) begin
				dig_nib = bcd_q[4*i +: 4];
			end
		end
	end

	// Character source for the current segment.
	always_comb begin
		unique case (uw.act)
			pifu_pkg::ACT_LPAD: begin
				seg_zero = (lpad_q == '0);
				emit_act = 1'b1;
				emit_char = pifu_pkg::CH_SPACE;
			end
			pifu_pkg::ACT_SIGN: begin
				seg_zero = !sign_q;
				emit_act = 1'b1;
				emit_char = pifu_pkg::CH_MINUS;
			end
			pifu_pkg::ACT_ZERO: begin
				seg_zero = (zc_q == '0);
				emit_act = 1'b1;
				emit_char = pifu_pkg::CH_ZERO;
			end
			pifu_pkg::ACT_DIGIT: begin
				seg_zero = (dig_q == '0);
				emit_act = 1'b1;
				emit_char = pifu_pkg::digit_char(dig_nib, kind_q);
			end
			pifu_pkg::ACT_RPAD: begin
				seg_zero = (rpad_q == '0);
				emit_act = 1'b1;
				emit_char = pifu_pkg::CH_SPACE;
			end
			default: begin
				seg_zero = 1'b1;
				emit_act = 1'b0;
				emit_char = pifu_pkg::CH_SPACE;
			end
		endcase
		emit = emit_act && !seg_zero && slot_free;
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= pifu_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Request capture and digit conversion.
	always_ff @(posedge clk) begin
		if (uw.act == pifu_pkg::ACT_LOAD && req_valid) begin
			neg_q <= value[63];
			mag_q <= value[63] ? (MAG_W'(0) - MAG_W'(value)) : MAG_W'(value);
			kind_q <= conv_kind;
			prec_pos_q <= !precision[6] && (precision[5:0] != 6'd0);
			prec_zero_q <= (precision == 7'sd0);
			prec_q <= prec_in;
			width_q <= width_in;
			zpad_q <= zero_pad;
			left_q <= left_align;
			bcd_q <= '0;
		end else if (uw.act == pifu_pkg::ACT_CONV) begin
			mag_q <= mag_d;
			bcd_q <= bcd_d;
		end
	end

	// Conversion and segment counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q <= '0;
			conv_cnt_q <= '0;
			lpad_q <= '0;
			sign_q <= 1'b0;
			zc_q <= '0;
			dig_q <= '0;
			rpad_q <= '0;
			rem_q <= '0;
		end else begin
			unique case (uw.act)
				pifu_pkg::ACT_LOAD: begin
					nd_q <= '0;
					conv_cnt_q <= '0;
				end
				pifu_pkg::ACT_CONV: begin
					nd_q <= nd_q + ND_W'(nd_grow);
					conv_cnt_q <= conv_cnt_q + CONV_W'(1);
				end
				pifu_pkg::ACT_SETUP: begin
					lpad_q <= left_q ? '0 : CNT_W'(s_spaces);
					rpad_q <= left_q ? CNT_W'(s_spaces) : '0;
					sign_q <= neg_q;
					zc_q <= CNT_W'(s_zc);
					dig_q <= ND_W'(s_nd);
					rem_q <= CNT_W'(s_nt + s_spaces);
				end
				pifu_pkg::ACT_LPAD: begin
					if (emit) lpad_q <= lpad_q - CNT_W'(1);
				end
				pifu_pkg::ACT_SIGN: begin
					if (emit) sign_q <= 1'b0;
				end
				pifu_pkg::ACT_ZERO: begin
					if (emit) zc_q <= zc_q - CNT_W'(1);
				end
				pifu_pkg::ACT_DIGIT: begin
					if (emit) dig_q <= dig_q - ND_W'(1);
				end
				pifu_pkg::ACT_RPAD: begin
					if (emit) rpad_q <= rpad_q - CNT_W'(1);
				end
			endcase
			if (emit) begin
				rem_q <= rem_q - CNT_W'(1);
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_char;
			is_last_q <= (rem_q == CNT_W'(1));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign out_char = out_char_q;
	assign is_last = is_last_q;

	// A character is only produced while characters of the request remain.
	`PIFU_ASSERT_IMP(a_emit_has_rem, clk, arst_n, emit, rem_q != '0)
	// The character marked last empties the remaining count.
	`PIFU_ASSERT_NXT(a_last_empties, clk, arst_n, emit && (rem_q == CNT_W'(1)), rem_q == '0)
	// A new request is taken only once all characters of the previous one are out.
	`PIFU_ASSERT_IMP(a_idle_drained, clk, arst_n, req_ready, rem_q == '0)
	// The digit count never passes the digit store.
	`PIFU_ASSERT_IMP(a_nd_range, clk, arst_n, 1'b1, nd_q <= ND_W'(NDIG))
	// Decimal digits stay below ten.
	`PIFU_ASSERT_IMP(a_dec_digit, clk, arst_n,
		(uw.act == pifu_pkg::ACT_DIGIT) && (dig_q != '0) && is_dec, dig_nib < 4'd10)

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for the integer formatter: directed and random requests checked character by character.
`timescale 1ns / 100ps

module tb;

	// Conversion kinds that the package leaves unnamed; both format as decimal.
	localparam logic [1:0] KIND_DEC     = 2'd0;
	localparam logic [1:0] KIND_ALT_DEC = 2'd3;

	// Field limit of the block and a bound above the longest text it can build.
	localparam int FIELD_LIMIT = pifu_pkg::MAX_WIDTH_DEF;
	localparam int TEXT_LIMIT  = pifu_pkg::MAX_WIDTH_DEF + 2;

	localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] MIXED_PATTERN = 64'sh7EDC_BA98_7654_3210;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	logic signed [63:0] value = '0;
	logic        [1:0]  conv_kind = '0;
	logic signed [6:0]  precision = '0;
	logic        [5:0]  field_width = '0;
	logic               zero_pad = 1'b0;
	logic               left_align = 1'b0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic        [7:0]  out_char;
	logic               is_last;

	// Characters still owed by the block, oldest first.
	text_char_t pending_chars[$];
	int unsigned mismatch_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	printf_integer_formatter_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.value      (value),
		.conv_kind  (conv_kind),
		.precision  (precision),
		.field_width(field_width),
		.zero_pad   (zero_pad),
		.left_align (left_align),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.out_char   (out_char),
		.is_last    (is_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Build the expected text of one request and queue its characters.
	function automatic void format_integer_text(
		input logic signed [63:0] v,
		input logic [1:0] kind,
		input logic signed [6:0] prec_in,
		input logic [5:0] width_in,
		input logic zpad,
		input logic left
	);
		string dec_set = "0123456789";
		string lower_set = "0123456789abcdef";
		string upper_set = "0123456789ABCDEF";
		logic neg;
		logic [63:0] mag;
		int prec;
		int width;
		int zeros;
		int pad;
		logic [7:0] digits[$];
		logic [7:0] body[$];
		logic [7:0] line[$];
		text_char_t entry;

		neg = v[63];
		mag = neg ? (64'd0 - v) : v;
		prec = int'(prec_in);
		width = int'(width_in);
		if (prec > FIELD_LIMIT) begin
			prec = FIELD_LIMIT;
		end
		if (width > FIELD_LIMIT) begin
			width = FIELD_LIMIT;
		end

		// Digits, most significant first; a zero precision blanks the value zero.
		if (!(prec == 0 && mag == 64'd0)) begin
			if (kind == pifu_pkg::KIND_LHEX || kind == pifu_pkg::KIND_UHEX) begin
				do begin
					digits.push_front((kind == pifu_pkg::KIND_LHEX) ? lower_set[mag[3:0]] :
						upper_set[mag[3:0]]);
					mag = mag >> 4;
				end while (mag != 64'd0);
			end else begin
				do begin
					digits.push_front(dec_set[int'(mag % 64'd10)]);
					mag = mag / 64'd10;
				end while (mag != 64'd0);
			end
		end

		// Leading zeros come from the precision, else from a zero-padded width.
		zeros = 0;
		if (prec > 0) begin
			if (prec > digits.size()) begin
				zeros = prec - digits.size();
			end
		end else if (zpad && !left) begin
			if (width > digits.size()) begin
				zeros = width - digits.size();
			end
		end
		for (int i = 0; i < zeros && body.size() < TEXT_LIMIT; i++) begin
			body.push_back(pifu_pkg::CH_ZERO);
		end
		foreach (digits[i]) begin
			if (body.size() < TEXT_LIMIT) begin
				body.push_back(digits[i]);
			end
		end
		// The sign takes the place of the first fill zero.
		if (prec <= 0 && zeros > 0 && neg) begin
			body[0] = pifu_pkg::CH_MINUS;
			neg = 1'b0;
		end

		if (neg) begin
			line.push_back(pifu_pkg::CH_MINUS);
		end
		foreach (body[i]) begin
			if (line.size() < TEXT_LIMIT) begin
				line.push_back(body[i]);
			end
		end

		// Space padding up to the field width.
		if (width > line.size()) begin
			pad = width - line.size();
			for (int i = 0; i < pad; i++) begin
				if (left) begin
					if (line.size() < TEXT_LIMIT) begin
						line.push_back(pifu_pkg::CH_SPACE);
					end
				end else begin
					line.push_front(pifu_pkg::CH_SPACE);
				end
			end
		end

		foreach (line[i]) begin
			entry.ch = line[i];
			entry.last = (i == line.size() - 1);
			pending_chars.push_back(entry);
		end
	endfunction

	// Receiver stalls at the rate of the current phase.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare every accepted character with the oldest one owed.
	always @(posedge clk) begin : check_chars
		text_char_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_chars.size() == 0) begin
				$error("out_char: expected none, actual %h", out_char);
				mismatch_count++;
			end else begin
				want = pending_chars.pop_front();
				if (out_char !== want.ch) begin
					$error("out_char: expected %h, actual %h", want.ch, out_char);
					mismatch_count++;
				end
				if (is_last !== want.last) begin
					$error("is_last: expected %0d, actual %0d", want.last, is_last);
					mismatch_count++;
				end
			end
		end
	end

	// Present one request, hold it until accepted, then predict its text.
	task automatic send_number(
		input logic signed [63:0] v,
		input logic [1:0] kind,
		input logic signed [6:0] prec,
		input logic [5:0] width,
		input logic zpad,
		input logic left
	);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		value <= v;
		conv_kind <= kind;
		precision <= prec;
		field_width <= width;
		zero_pad <= zpad;
		left_align <= left;
		do @(posedge clk); while (!req_ready);
		format_integer_text(v, kind, prec, width, zpad, left);
	endtask

	// Hold off new requests until every owed character has come out.
	task automatic pause_until_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
	endtask

	function automatic logic signed [63:0] pick_value();
		logic signed [63:0] v;
		case ($urandom_range(5))
			0, 1: v = {$urandom(), $urandom()};
			2: v = 64'($urandom_range(999));
			3: begin
				v = 64'sd1 << $urandom_range(63);
				if ($urandom_range(1)) begin
					v = v - 64'sd1;
				end
			end
			4: v = 64'sd0;
			default: begin
				case ($urandom_range(3))
					0: v = INT64_MIN;
					1: v = INT64_MAX;
					2: v = -64'sd1;
					default: v = 64'sd1;
				endcase
			end
		endcase
		if ($urandom_range(1)) begin
			v = -v;
		end
		return v;
	endfunction

	function automatic logic signed [6:0] pick_precision();
		case ($urandom_range(4))
			0: return -7'sd1;
			1: return 7'($urandom_range(12));
			2: return 7'($urandom_range(FIELD_LIMIT));
			3: return 7'sd0;
			default: return 7'($urandom());
		endcase
	endfunction

	function automatic logic [5:0] pick_width();
		case ($urandom_range(3))
			0: return 6'($urandom_range(12));
			1: return 6'($urandom_range(24));
			2: return 6'($urandom());
			default: return 6'd0;
		endcase
	endfunction

	// Zero, the blank zero, the largest magnitudes, decimal and both hex kinds.
	task automatic test_value_extremes();
		send_number(64'sd0, KIND_DEC, -7'sd1, 6'd0, 1'b0, 1'b0);
		send_number(64'sd0, KIND_DEC, 7'sd0, 6'd0, 1'b0, 1'b0);
		send_number(64'sd0, pifu_pkg::KIND_LHEX, 7'sd0, 6'd5, 1'b0, 1'b0);
		send_number(64'sd5, KIND_DEC, 7'sd0, 6'd0, 1'b0, 1'b0);
		send_number(INT64_MIN, KIND_DEC, -7'sd1, 6'd0, 1'b0, 1'b0);
		send_number(INT64_MAX, pifu_pkg::KIND_UHEX, -7'sd1, 6'd0, 1'b0, 1'b0);
		send_number(INT64_MAX, KIND_DEC, -7'sd1, 6'd0, 1'b0, 1'b0);
		send_number(-64'sd1, pifu_pkg::KIND_LHEX, -7'sd1, 6'd0, 1'b0, 1'b0);
		send_number(MIXED_PATTERN, pifu_pkg::KIND_LHEX, -7'sd1, 6'd0, 1'b0, 1'b0);
		send_number(MIXED_PATTERN, pifu_pkg::KIND_UHEX, -7'sd1, 6'd0, 1'b0, 1'b0);
	endtask

	// Zero fill with sign, left alignment, precision over zero fill, odd precisions.
	task automatic test_padding_rules();
		send_number(-64'sd42, KIND_DEC, -7'sd1, 6'd8, 1'b1, 1'b0);
		send_number(-64'sd42, KIND_DEC, -7'sd1, 6'd8, 1'b1, 1'b1);
		send_number(64'sd42, KIND_DEC, 7'sd5, 6'd10, 1'b1, 1'b0);
		send_number(-64'sd42, KIND_DEC, 7'sd5, 6'd10, 1'b0, 1'b1);
		send_number(64'sd255, pifu_pkg::KIND_LHEX, -7'sd2, 6'd10, 1'b1, 1'b0);
		send_number(-64'sd255, pifu_pkg::KIND_UHEX, -7'sd64, 6'd6, 1'b1, 1'b0);
		send_number(64'sd123456, KIND_DEC, -7'sd1, 6'd3, 1'b1, 1'b0);
	endtask

	// Saturated precision and width, the longest texts, and the fourth kind code.
	task automatic test_option_limits();
		send_number(-64'sd5, KIND_DEC, 7'sd63, 6'd0, 1'b0, 1'b0);
		send_number(64'sd7, KIND_DEC, -7'sd1, 6'd63, 1'b0, 1'b1);
		send_number(INT64_MIN, KIND_DEC, -7'sd1, 6'd63, 1'b1, 1'b0);
		send_number(INT64_MIN, pifu_pkg::KIND_LHEX, 7'sd40, 6'd40, 1'b0, 1'b0);
		send_number(-64'sd99, KIND_ALT_DEC, 7'sd3, 6'd6, 1'b0, 1'b0);
		send_number(64'sd0, pifu_pkg::KIND_UHEX, 7'sd0, 6'd63, 1'b1, 1'b0);
	endtask

	// Random requests under one idling pattern, starting from an empty pipeline.
	task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
		pause_until_drained();
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) begin
			send_number(pick_value(), 2'($urandom_range(3)), pick_precision(), pick_width(),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_value_extremes();
		test_padding_rules();
		test_option_limits();
		test_random_traffic(100, 0, 0);
		test_random_traffic(100, 56, 0);
		test_random_traffic(100, 0, 56);
		test_random_traffic(100, 25, 25);

		// Let the last request finish, including one that prints nothing.
		pause_until_drained();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
